// ----- rtl/core/pidc_pkg.sv -----
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, constants and saturation helpers of the PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

	// number format: signed Q16.16 in a 32-bit word
	localparam int DW        = 32;
	localparam int FRAC_BITS = 16;
	localparam int MAG_W     = DW + FRAC_BITS;   // product >> FRAC, dividend, quotient
	localparam int LIM_W     = DW - 1;           // unsigned limits and period
	localparam int DECAY_W   = 17;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_THR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_FAC = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd7;

	// reset values
	localparam logic [LIM_W-1:0]   RST_INT_LIMIT = {LIM_W{1'b1}};
	localparam logic [DECAY_W-1:0] RST_DECAY_FAC = 17'd65536;
	localparam logic [LIM_W-1:0]   RST_PERIOD    = 31'd66;

	// operation codes carried in tuser
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// request to the shared multiplier: a * b >> FRAC_BITS, rounded toward zero
	typedef struct packed {
		logic                 valid;
		logic signed [DW-1:0] a;
		logic signed [DW:0]   b;
	} mul_req_t;

	// signed value from sign and magnitude, saturated to the data range
	function automatic logic signed [DW-1:0] sat_mag(input logic neg,
			input logic [MAG_W-1:0] m);
		logic [MAG_W-1:0] lim;
		logic [DW-1:0]    lo;
		lim = MAG_W'(1) << (DW - 1);
		lo  = m[DW-1:0];
		if (m >= lim) begin
			return neg ? DMIN : DMAX;
		end
		return neg ? -$signed(lo) : $signed(lo);
	endfunction

	// saturating add of two data words
	function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		logic [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1]) begin
			return s[DW] ? DMIN : DMAX;
		end
		return $signed(s[DW-1:0]);
	endfunction

endpackage

// ----- rtl/core/pidc_mul.sv -----
// ----------------------------------------------------------------------------
// pidc_mul
// Shared fractional multiplier: magnitude stage, 32x32 product stage, then
// shift and saturate. One request per cycle.
// ----------------------------------------------------------------------------
module pidc_mul
	import pidc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  mul_req_t             req,
	output logic                 res_valid,
	output logic signed [DW-1:0] res
);

	logic          v_s1, v_s2;
	logic          neg_s1, neg_s2;
	logic [DW-1:0] ma_s1, mb_s1;
	logic [2*DW-1:0] prod_s2;

	logic [DW-1:0] ma;
	logic [DW:0]   mb;

	assign ma = req.a[DW-1] ? (~req.a + 1'b1) : req.a;
	assign mb = req.b[DW] ? (~req.b + 1'b1) : req.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= req.a[DW-1] ^ req.b[DW];
		ma_s1   <= ma;
		mb_s1   <= mb[DW-1:0];
		neg_s2  <= neg_s1;
		prod_s2 <= ma_s1 * mb_s1;
	end

	assign res_valid = v_s2;
	assign res       = sat_mag(neg_s2, prod_s2[2*DW-1:FRAC_BITS]);

endmodule

// ----- rtl/core/pidc_div.sv -----
// ----------------------------------------------------------------------------
// pidc_div
// Restoring divider, one quotient bit per cycle, for the derivative term.
// ----------------------------------------------------------------------------
module pidc_div
	import pidc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] dividend,
	input  logic [LIM_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [MAG_W-1:0] quo
);

	localparam int CNT_W = $clog2(MAG_W);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [LIM_W-1:0] rem_q, dvs_q;
	logic [MAG_W-1:0] num_q;

	logic [DW-1:0] trial, diff;
	logic          ge;

	assign trial = {rem_q, num_q[MAG_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MAG_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LIM_W-1:0] : trial[LIM_W-1:0];
			num_q <= {num_q[MAG_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;

endmodule

// ----- rtl/core/pid_integral_decay_controller.sv -----
// ----------------------------------------------------------------------------
// pid_integral_decay_controller
// PID controller in signed Q16.16 with integral decay, integral clamp and
// drive clamp, built around one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------
// s_*      | in        | s_tvalid/s_tready  | tdata: error; tuser: op
// m_*      | out       | m_tvalid/m_tready  | tdata: drive; tuser: iclamp, dclamp
// cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An update transaction runs the 48-step derivative divider, which sets the
// length of an update; the three multiplies of the integral, P and I terms
// run under it. The next transaction is taken once the result has moved into
// the output register. A clear transaction completes in the idle state and
// yields no result. Reset clears the integral, the previous error and loads
// the register defaults. A held result waits in the output register while
// the block already accepts the next transaction.
//
module pid_integral_decay_controller
	import pidc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DW-1:0]        s_tdata,   // [31:0] error
	input  logic                 s_tuser,   // [0] op
	// output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DW-1:0]        m_tdata,   // [31:0] drive
	output logic [1:0]           m_tuser,   // [0] integral_clamped, [1] drive_clamped
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DW-1:0]        cfg_data
);

	// sequencer states
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_INT_MUL  = 4'd1;
	localparam logic [3:0] ST_INT_WAIT = 4'd2;
	localparam logic [3:0] ST_P_MUL    = 4'd3;
	localparam logic [3:0] ST_P_WAIT   = 4'd4;
	localparam logic [3:0] ST_I_MUL    = 4'd5;
	localparam logic [3:0] ST_I_WAIT   = 4'd6;
	localparam logic [3:0] ST_D_DIV    = 4'd7;
	localparam logic [3:0] ST_D_MUL    = 4'd8;
	localparam logic [3:0] ST_D_WAIT   = 4'd9;
	localparam logic [3:0] ST_DONE     = 4'd10;

	logic [3:0] state_q;

	// configuration registers
	logic signed [DW-1:0] gp_q, gi_q, gd_q;
	logic [LIM_W-1:0]     ilim_q, olim_q, thr_q, dt_q;
	logic [DECAY_W-1:0]   decay_q;

	// controller state and working registers
	logic signed [DW-1:0] integ_q, last_q;
	logic signed [DW-1:0] err_q, acc_q, deriv_q;
	logic                 decay_sel_q, diff_neg_q, iclamp_q;

	// output register
	logic                 m_valid_q;
	logic [DW-1:0]        m_data_q;
	logic [1:0]           m_user_q;

	// ------------------------------------------------------------------
	// configuration port: always ready, a write lands at the end of its handshake cycle
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q    <= '0;
			gi_q    <= '0;
			gd_q    <= '0;
			ilim_q  <= RST_INT_LIMIT;
			olim_q  <= '0;
			thr_q   <= '0;
			decay_q <= RST_DECAY_FAC;
			dt_q    <= RST_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_P:    gp_q    <= $signed(cfg_data);
				REG_GAIN_I:    gi_q    <= $signed(cfg_data);
				REG_GAIN_D:    gd_q    <= $signed(cfg_data);
				REG_INT_LIMIT: ilim_q  <= cfg_data[LIM_W-1:0];
				REG_OUT_LIMIT: olim_q  <= cfg_data[LIM_W-1:0];
				REG_DECAY_THR: thr_q   <= cfg_data[LIM_W-1:0];
				REG_DECAY_FAC: decay_q <= cfg_data[DECAY_W-1:0];
				REG_PERIOD:    dt_q    <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// input decode at acceptance
	// ------------------------------------------------------------------
	logic             s_acc, upd_acc, clr_acc;
	logic [LIM_W-1:0] dt_eff;
	logic [DW-1:0]    err_mag;
	logic [DW:0]      diff, diff_mag;
	logic [MAG_W-1:0] div_dividend;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign upd_acc  = s_acc && (s_tuser == OP_UPDATE);
	assign clr_acc  = s_acc && (s_tuser == OP_CLEAR);

	// a zero period counts as one
	assign dt_eff = (dt_q == '0) ? LIM_W'(1) : dt_q;

	assign err_mag  = s_tdata[DW-1] ? (~s_tdata + 1'b1) : s_tdata;
	assign diff     = {s_tdata[DW-1], s_tdata} - {last_q[DW-1], last_q};
	assign diff_mag = diff[DW] ? (~diff + 1'b1) : diff;
	assign div_dividend = {diff_mag[DW-1:0], {FRAC_BITS{1'b0}}};

	// ------------------------------------------------------------------
	// shared multiplier and derivative divider
	// ------------------------------------------------------------------
	mul_req_t             mul_req;
	logic                 mul_valid;
	logic signed [DW-1:0] mul_res;
	logic                 div_busy, div_done;
	logic [MAG_W-1:0]     div_quo;

	always_comb begin
		mul_req = '{valid: 1'b0, a: err_q, b: {gp_q[DW-1], gp_q}};
		case (state_q)
			ST_INT_MUL: begin
				mul_req.valid = 1'b1;
				if (decay_sel_q) begin
					mul_req.a = integ_q;
					mul_req.b = $signed((DW + 1)'(decay_q));
				end else begin
					mul_req.a = err_q;
					mul_req.b = $signed((DW + 1)'(dt_eff));
				end
			end
			ST_P_MUL: begin
				mul_req.valid = 1'b1;
			end
			ST_I_MUL: begin
				mul_req.valid = 1'b1;
				mul_req.a     = integ_q;
				mul_req.b     = {gi_q[DW-1], gi_q};
			end
			ST_D_MUL: begin
				mul_req.valid = 1'b1;
				mul_req.a     = deriv_q;
				mul_req.b     = {gd_q[DW-1], gd_q};
			end
			default: ;
		endcase
	end

	pidc_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (mul_req),
		.res_valid (mul_valid),
		.res       (mul_res)
	);

	pidc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (upd_acc),
		.dividend (div_dividend),
		.divisor  (dt_eff),
		.busy     (div_busy),
		.done     (div_done),
		.quo      (div_quo)
	);

	// ------------------------------------------------------------------
	// integral update and clamp, drive clamp
	// ------------------------------------------------------------------
	logic signed [DW-1:0] integ_raw, integ_next, ilim_s, olim_s, drive_next;
	logic                 iclamp_next, dclamp_next;

	assign ilim_s = $signed({1'b0, ilim_q});
	assign olim_s = $signed({1'b0, olim_q});

	always_comb begin
		// decay replaces the integral, otherwise accumulate e*dt
		integ_raw   = decay_sel_q ? mul_res : sat_add(integ_q, mul_res);
		integ_next  = integ_raw;
		iclamp_next = 1'b0;
		if (integ_raw > ilim_s) begin
			integ_next  = ilim_s;
			iclamp_next = 1'b1;
		end else if (integ_raw < -ilim_s) begin
			integ_next  = -ilim_s;
			iclamp_next = 1'b1;
		end

		// a zero output limit leaves the drive unclamped
		drive_next  = acc_q;
		dclamp_next = 1'b0;
		if (olim_q != '0) begin
			if (acc_q > olim_s) begin
				drive_next  = olim_s;
				dclamp_next = 1'b1;
			end else if (acc_q < -olim_s) begin
				drive_next  = -olim_s;
				dclamp_next = 1'b1;
			end
		end
	end

	logic out_free;
	assign out_free = !m_valid_q || m_tready;

	// ------------------------------------------------------------------
	// sequencer and controller state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			integ_q <= '0;
			last_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (clr_acc) begin
						integ_q <= '0;
						last_q  <= '0;
					end else if (upd_acc) begin
						state_q <= ST_INT_MUL;
					end
				end
				ST_INT_MUL: state_q <= ST_INT_WAIT;
				ST_INT_WAIT: begin
					if (mul_valid) begin
						integ_q <= integ_next;
						state_q <= ST_P_MUL;
					end
				end
				ST_P_MUL: state_q <= ST_P_WAIT;
				ST_P_WAIT: begin
					if (mul_valid) begin
						state_q <= ST_I_MUL;
					end
				end
				ST_I_MUL: state_q <= ST_I_WAIT;
				ST_I_WAIT: begin
					if (mul_valid) begin
						state_q <= ST_D_DIV;
					end
				end
				ST_D_DIV: begin
					if (div_done) begin
						state_q <= ST_D_MUL;
					end
				end
				ST_D_MUL: state_q <= ST_D_WAIT;
				ST_D_WAIT: begin
					if (mul_valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold here until the output register frees up
					if (out_free) begin
						last_q  <= err_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers carry no reset
	always_ff @(posedge clk) begin
		if (upd_acc) begin
			err_q       <= $signed(s_tdata);
			decay_sel_q <= {1'b0, err_mag} < {2'b0, thr_q};
			diff_neg_q  <= diff[DW];
		end
		if (state_q == ST_INT_WAIT && mul_valid) begin
			iclamp_q <= iclamp_next;
		end
		if (state_q == ST_P_WAIT && mul_valid) begin
			acc_q <= mul_res;
		end
		if ((state_q == ST_I_WAIT || state_q == ST_D_WAIT) && mul_valid) begin
			acc_q <= sat_add(acc_q, mul_res);
		end
		if (state_q == ST_D_DIV && div_done) begin
			deriv_q <= sat_mag(diff_neg_q, div_quo);
		end
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= drive_next;
			m_user_q <= {dclamp_next, iclamp_q};
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

`ifndef SYNTHESIS
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_busy)
		else $error("divider busy while sequencer idle");

	a_update_starts: assert property (@(posedge clk) disable iff (!arst_n)
		upd_acc |=> (state_q == ST_INT_MUL) && div_busy)
		else $error("update transaction did not start the sequence");

	a_mul_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_valid |-> (state_q == ST_INT_WAIT || state_q == ST_P_WAIT ||
			state_q == ST_I_WAIT || state_q == ST_D_WAIT))
		else $error("multiplier result outside a wait state");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		clr_acc |=> (integ_q == '0) && (last_q == '0))
		else $error("clear transaction left state nonzero");
`endif

endmodule
